// ----- hdl/x86_copy_fill_loop_recognizer_defines.svh -----
// ----------------------------------------------------------------------------
// x86_copy_fill_loop_recognizer_defines
// assertion macros for the copy/fill loop recognizer
// ----------------------------------------------------------------------------
`ifndef X86_COPY_FILL_LOOP_RECOGNIZER_DEFINES_SVH
`define X86_COPY_FILL_LOOP_RECOGNIZER_DEFINES_SVH

// property holds at every clock edge outside reset
`define XCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property holds in the cycle after the trigger, outside reset
`define XCF_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/xcfl_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfl_pkg
// types and constants shared by the copy/fill loop recognizer
// ----------------------------------------------------------------------------
package xcfl_pkg;

   localparam int MaxLoopBytes = 64;

   typedef enum logic [2:0] {
      PH_START, PH_OPCODE, PH_OP2, PH_MODRM, PH_IMM, PH_JNZ, PH_REL
   } phase_type;

   localparam logic [2:0] VK_NONE = 3'd0;
   localparam logic [2:0] VK_GPR  = 3'd1;
   localparam logic [2:0] VK_MMX  = 3'd2;
   localparam logic [2:0] VK_XMM  = 3'd3;
   localparam logic [2:0] VK_IMM  = 3'd4;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [7:0]  pattern_length;
      logic [7:0]  insn_total;
      logic [4:0]  element_size;
      logic        loop_kind;
      logic [2:0]  source_reg;
      logic [2:0]  dest_reg;
      logic [2:0]  counter_reg;
      logic [2:0]  value_class;
      logic [2:0]  value_reg_out;
      logic [31:0] value_immediate;
   } rsp_type;

   // window state carried between bytes
   typedef struct packed {
      logic [7:0]  byte_position;
      phase_type   decode_phase;
      logic [7:0]  prefix_seen;
      logic [7:0]  rex_held;
      logic [7:0]  opcode_held;
      logic [7:0]  second_opcode;
      logic [7:0]  modrm_held;
      logic [31:0] imm_accum;
      logic [2:0]  imm_bytes_left;
      logic [2:0]  imm_total;
      logic        failed;
      logic        tail_found;
      logic [2:0]  tail_counter;
      logic        load_seen;
      logic        store_seen;
      logic        store_from_imm;
      logic [2:0]  load_value_reg;
      logic [2:0]  load_value_kind;
      logic [4:0]  load_width;
      logic [2:0]  load_pointer;
      logic [2:0]  store_value_reg;
      logic [2:0]  store_value_kind;
      logic [4:0]  store_width;
      logic [2:0]  store_pointer;
      logic [31:0] store_imm_word;
      logic [7:0]  insn_count;
   } win_type;

endpackage

// ----- hdl/xcfl_stream_if.sv -----
// ----------------------------------------------------------------------------
// xcfl_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface xcfl_stream_if #(type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/x86_copy_fill_loop_recognizer.sv -----
// ----------------------------------------------------------------------------
// x86_copy_fill_loop_recognizer
// streams a candidate loop body byte by byte and judges it a copy/fill loop
// ----------------------------------------------------------------------------
// channel  dir  payload                     word
// req      in   code_byte, last_byte        one code byte
// rsp      out  verdict fields              one verdict per window
// csr      in   long_mode                   register write
//
// one byte per cycle; decode of a byte is one combinational step off the
// window state registers, so a byte can enter every cycle.
// the verdict is registered and shows in the cycle after the last byte is taken.
// a stalled verdict blocks only a next last byte; other bytes keep flowing.
// reset clears window state, long_mode and the output valid.
// ----------------------------------------------------------------------------
`include "x86_copy_fill_loop_recognizer_defines.svh"

module x86_copy_fill_loop_recognizer
   import xcfl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   xcfl_stream_if.sink   req,
   xcfl_stream_if.source rsp,
   input  logic csr_we,
   input  logic csr_wdata
);

   logic        long_mode_ff;
   win_type     win_ff, win_in;
   logic [31:0] adv_ff [8];
   logic [31:0] adv_in [8];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, verdict_in;
   logic        req_fire, last_fire;
   req_type     rq;

   assign rq = req.payload;
   assign req.ready = !rq.last_byte || !rsp_valid_ff || rsp.ready;
   assign req_fire = req.valid && req.ready;
   assign last_fire = req_fire && rq.last_byte;

   xcfl_decoder u_dec (
      .win(win_ff), .adv(adv_ff), .long_mode(long_mode_ff), .b(rq.code_byte),
      .win_in(win_in), .adv_in(adv_in)
   );

   xcfl_verdict u_vrd (.w(win_in), .adv(adv_in), .rsp(verdict_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         long_mode_ff <= 1'b0;
         win_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) adv_ff[i] <= 32'd0;
      end else begin
         if (csr_we) long_mode_ff <= csr_wdata;
         if (last_fire) begin
            win_ff <= '0;
            for (int i = 0; i < 8; i++) adv_ff[i] <= 32'd0;
         end else if (req_fire) begin
            win_ff <= win_in;
            adv_ff <= adv_in;
         end
         if (last_fire) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_fire) rsp_ff <= verdict_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `XCF_ASSERT_NEXT(a_rsp_after_last, last_fire, rsp_valid_ff, "no verdict after last byte")
   `XCF_ASSERT(a_no_overwrite, (rsp_valid_ff && !rsp.ready) |-> !last_fire, "verdict lost")
   `XCF_ASSERT_NEXT(a_clear_after_last, last_fire, win_ff.byte_position == 8'd0, "no clear")

endmodule

// ----- hdl/xcfl_decoder.sv -----
// ----------------------------------------------------------------------------
// xcfl_decoder
// per-byte decode step: window state and advance sums in, next state out
// ----------------------------------------------------------------------------
module xcfl_decoder
   import xcfl_pkg::*;
(
   input  win_type     win,
   input  logic [31:0] adv [8],
   input  logic        long_mode,
   input  logic [7:0]  b,
   output win_type     win_in,
   output logic [31:0] adv_in [8]
);

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] n);
      logic [8:0] t;
      t = {1'b0, a} + {7'd0, n};
      return t[8] ? 8'hff : t[7:0];
   endfunction

   function automatic logic plain_base(input logic [7:0] m);
      return m[7:6] == 2'b00 && m[2:0] != 3'd4 && m[2:0] != 3'd5;
   endfunction

   always_comb begin
      win_type      w;
      logic [31:0]  a [8];
      logic         pre;
      logic [2:0]   rm, rg;
      logic [1:0]   md;
      logic [2:0]   kind;
      logic [4:0]   size;
      logic         st;
      logic [31:0]  acc, v;
      logic [2:0]   left;
      logic signed [8:0] rel;
      logic         adv_en, do_end, do_imm;
      logic [2:0]   adv_reg;
      logic [31:0]  adv_val;
      logic [2:0]   imm_n;
      logic [7:0]   at;
      w = win;
      a = adv;
      pre = win.prefix_seen != 8'h00;
      rm = b[2:0];
      rg = b[5:3];
      md = b[7:6];
      kind = VK_XMM;
      size = 5'd16;
      st = 1'b0;
      acc = {b, win.imm_accum[31:8]};
      left = 3'd0;
      v = 32'd0;
      rel = 9'sd0;
      adv_en = 1'b0;
      do_end = 1'b0;
      do_imm = 1'b0;
      adv_reg = 3'd0;
      adv_val = 32'd0;
      imm_n = 3'd0;
      at = win.byte_position;
      if (!win.tail_found) begin
         if (win.byte_position != 8'hff) begin
            w.byte_position = win.byte_position + 8'd1;
         end
         if (!win.failed) begin
            if ({24'd0, at} >= 32'(MaxLoopBytes)) begin
               w.failed = 1'b1;
            end else begin
               case (win.decode_phase)
                  PH_START, PH_OPCODE: begin
                     if (win.decode_phase == PH_START &&
                         (b == 8'h66 || b == 8'hf2 || b == 8'hf3)) begin
                        if (pre && win.prefix_seen != b) w.failed = 1'b1;
                        else w.prefix_seen = b;
                     end else if (win.decode_phase == PH_START && long_mode &&
                                  b[7:4] == 4'h4) begin
                        w.rex_held = b;
                        if (b[2:0] != 3'd0) w.failed = 1'b1;
                        else w.decode_phase = PH_OPCODE;
                     end else begin
                        w.opcode_held = b;
                        if (!long_mode && b[7:4] == 4'h4) begin
                           if (pre) begin
                              w.failed = 1'b1;
                           end else begin
                              adv_en = 1'b1;
                              adv_reg = b[2:0];
                              adv_val = b[3] ? 32'hffffffff : 32'd1;
                              do_end = 1'b1;
                           end
                        end else begin
                           case (b)
                              8'h0f: w.decode_phase = PH_OP2;
                              8'h8b, 8'h8a: begin
                                 if (pre || win.load_seen || win.store_seen) w.failed = 1'b1;
                                 else w.decode_phase = PH_MODRM;
                              end
                              8'h89, 8'h88: begin
                                 if (pre || win.store_seen) w.failed = 1'b1;
                                 else w.decode_phase = PH_MODRM;
                              end
                              8'hc7: begin
                                 if (pre || win.rex_held != 8'h00 || win.store_seen)
                                    w.failed = 1'b1;
                                 else w.decode_phase = PH_MODRM;
                              end
                              8'h81, 8'h83, 8'h8d, 8'hff: begin
                                 if (pre) w.failed = 1'b1;
                                 else w.decode_phase = PH_MODRM;
                              end
                              8'he2: begin
                                 if (pre || win.rex_held != 8'h00) begin
                                    w.failed = 1'b1;
                                 end else begin
                                    w.tail_counter = 3'd1;
                                    w.insn_count = sat_add(win.insn_count, 2'd1);
                                    w.decode_phase = PH_REL;
                                 end
                              end
                              default: w.failed = 1'b1;
                           endcase
                        end
                     end
                  end
                  PH_OP2: begin
                     if (b == 8'h6f || b == 8'h7f || b == 8'h10 || b == 8'h11 ||
                         b == 8'h28 || b == 8'h29) begin
                        w.second_opcode = b;
                        w.decode_phase = PH_MODRM;
                     end else begin
                        w.failed = 1'b1;
                     end
                  end
                  PH_MODRM: begin
                     w.modrm_held = b;
                     case (win.opcode_held)
                        8'h0f: begin
                           if (win.second_opcode == 8'h6f || win.second_opcode == 8'h7f) begin
                              if (!pre) begin
                                 kind = VK_MMX;
                                 size = 5'd8;
                              end
                              st = win.second_opcode == 8'h7f;
                           end else begin
                              if (win.prefix_seen == 8'hf2) size = 5'd8;
                              else if (win.prefix_seen == 8'hf3) size = 5'd4;
                              st = win.second_opcode[0];
                           end
                           if (!plain_base(b)) begin
                              w.failed = 1'b1;
                           end else if (st) begin
                              if (win.store_seen) begin
                                 w.failed = 1'b1;
                              end else begin
                                 w.store_seen = 1'b1;
                                 w.store_from_imm = 1'b0;
                                 w.store_pointer = rm;
                                 w.store_value_reg = rg;
                                 w.store_value_kind = kind;
                                 w.store_width = size;
                                 do_end = 1'b1;
                              end
                           end else begin
                              if (win.load_seen || win.store_seen) begin
                                 w.failed = 1'b1;
                              end else begin
                                 w.load_seen = 1'b1;
                                 w.load_pointer = rm;
                                 w.load_value_reg = rg;
                                 w.load_value_kind = kind;
                                 w.load_width = size;
                                 do_end = 1'b1;
                              end
                           end
                        end
                        8'h8b, 8'h8a, 8'h89, 8'h88: begin
                           size = win.opcode_held[0] ? (win.rex_held[3] ? 5'd8 : 5'd4)
                                                     : 5'd1;
                           if (!plain_base(b)) begin
                              w.failed = 1'b1;
                           end else if (!win.opcode_held[0] || win.opcode_held == 8'h8b) begin
                              if (win.opcode_held[1]) begin
                                 w.load_seen = 1'b1;
                                 w.load_pointer = rm;
                                 w.load_value_reg = rg;
                                 w.load_value_kind = VK_GPR;
                                 w.load_width = size;
                              end else begin
                                 w.store_seen = 1'b1;
                                 w.store_from_imm = 1'b0;
                                 w.store_pointer = rm;
                                 w.store_value_reg = rg;
                                 w.store_value_kind = VK_GPR;
                                 w.store_width = size;
                              end
                              do_end = 1'b1;
                           end else begin
                              // 0x89 store
                              w.store_seen = 1'b1;
                              w.store_from_imm = 1'b0;
                              w.store_pointer = rm;
                              w.store_value_reg = rg;
                              w.store_value_kind = VK_GPR;
                              w.store_width = size;
                              do_end = 1'b1;
                           end
                        end
                        8'hc7: begin
                           if (!plain_base(b) || rg != 3'd0) begin
                              w.failed = 1'b1;
                           end else begin
                              w.store_seen = 1'b1;
                              w.store_from_imm = 1'b1;
                              w.store_pointer = rm;
                              w.store_value_reg = 3'd0;
                              w.store_value_kind = VK_IMM;
                              w.store_width = 5'd4;
                              do_imm = 1'b1;
                              imm_n = 3'd4;
                           end
                        end
                        8'h81, 8'h83: begin
                           if (md != 2'b11 || (rg != 3'd0 && rg != 3'd5)) begin
                              w.failed = 1'b1;
                           end else begin
                              do_imm = 1'b1;
                              imm_n = (win.opcode_held == 8'h83) ? 3'd1 : 3'd4;
                           end
                        end
                        8'h8d: begin
                           if ((md != 2'b01 && md != 2'b10) || rm == 3'd4 || rg != rm) begin
                              w.failed = 1'b1;
                           end else begin
                              do_imm = 1'b1;
                              imm_n = (md == 2'b01) ? 3'd1 : 3'd4;
                           end
                        end
                        default: begin
                           if (md != 2'b11 || rg > 3'd1) begin
                              w.failed = 1'b1;
                           end else if (rg == 3'd0) begin
                              adv_en = 1'b1;
                              adv_reg = rm;
                              adv_val = 32'd1;
                              do_end = 1'b1;
                           end else begin
                              w.tail_counter = rm;
                              w.insn_count = sat_add(win.insn_count, 2'd2);
                              w.decode_phase = PH_JNZ;
                           end
                        end
                     endcase
                  end
                  PH_IMM: begin
                     w.imm_accum = acc;
                     left = (win.imm_bytes_left != 3'd0) ? win.imm_bytes_left - 3'd1
                                                         : 3'd0;
                     w.imm_bytes_left = left;
                     if (left == 3'd0) begin
                        v = (win.imm_total == 3'd1) ? {{24{acc[31]}}, acc[31:24]} : acc;
                        if (win.opcode_held == 8'hc7) begin
                           w.store_imm_word = v;
                           do_end = 1'b1;
                        end else if (win.opcode_held == 8'h8d ||
                                     win.modrm_held[5:3] == 3'd0) begin
                           adv_en = 1'b1;
                           adv_reg = win.modrm_held[2:0];
                           adv_val = v;
                           do_end = 1'b1;
                        end else if (v == 32'd1) begin
                           w.tail_counter = win.modrm_held[2:0];
                           w.insn_count = sat_add(win.insn_count, 2'd2);
                           w.decode_phase = PH_JNZ;
                        end else begin
                           w.failed = 1'b1;
                        end
                     end
                  end
                  PH_JNZ: begin
                     if (b == 8'h75) w.decode_phase = PH_REL;
                     else w.failed = 1'b1;
                  end
                  PH_REL: begin
                     // branch must land on position zero
                     rel = $signed({b[7], b});
                     if (rel + $signed({1'b0, at}) + 9'sd1 != 9'sd0) w.failed = 1'b1;
                     else w.tail_found = 1'b1;
                  end
                  default: w.failed = 1'b1;
               endcase
            end
         end
      end
      if (do_imm) begin
         w.imm_accum = 32'd0;
         w.imm_total = imm_n;
         w.imm_bytes_left = imm_n;
         w.decode_phase = PH_IMM;
      end
      if (do_end) begin
         w.insn_count = sat_add(win.insn_count, 2'd1);
         w.decode_phase = PH_START;
         w.prefix_seen = 8'h00;
         w.rex_held = 8'h00;
      end
      if (adv_en) begin
         a[adv_reg] = adv[adv_reg] + adv_val;
      end
      win_in = w;
      adv_in = a;
   end

endmodule

// ----- hdl/xcfl_verdict.sv -----
// ----------------------------------------------------------------------------
// xcfl_verdict
// final acceptance check over the window state and the eight advance sums
// ----------------------------------------------------------------------------
module xcfl_verdict
   import xcfl_pkg::*;
(
   input  win_type     w,
   input  logic [31:0] adv [8],
   output rsp_type     rsp
);

   always_comb begin
      logic       ok;
      logic [2:0] src;
      logic       ptr;
      ok = !w.failed && w.tail_found && w.store_seen;
      src = w.store_pointer;
      if (w.load_seen) begin
         if (w.load_value_reg != w.store_value_reg ||
             w.load_value_kind != w.store_value_kind || w.load_width != w.store_width)
            ok = 1'b0;
         if (w.load_value_kind == VK_GPR && (w.load_value_reg == w.load_pointer ||
             w.load_value_reg == w.store_pointer))
            ok = 1'b0;
         src = w.load_pointer;
      end
      if (w.store_width != 5'd1 && w.store_width != 5'd4 && w.store_width != 5'd8 &&
          w.store_width != 5'd16)
         ok = 1'b0;
      for (int r = 0; r < 8; r++) begin
         ptr = 3'(r) == w.store_pointer || (w.load_seen && 3'(r) == src);
         if (adv[r] != (ptr ? {27'd0, w.store_width} : 32'd0)) ok = 1'b0;
      end
      if (w.tail_counter == w.store_pointer || (w.load_seen && w.tail_counter == src) ||
          adv[w.tail_counter] != 32'd0)
         ok = 1'b0;
      if (!w.load_seen && w.store_value_kind == VK_GPR &&
          (w.store_value_reg == w.store_pointer || w.store_value_reg == w.tail_counter))
         ok = 1'b0;
      rsp = '0;
      if (ok) begin
         rsp.accepted = 1'b1;
         rsp.pattern_length = w.byte_position;
         rsp.insn_total = w.insn_count;
         rsp.element_size = w.store_width;
         rsp.loop_kind = !w.load_seen;
         rsp.source_reg = src;
         rsp.dest_reg = w.store_pointer;
         rsp.counter_reg = w.tail_counter;
         rsp.value_class = w.load_seen ? VK_NONE : w.store_value_kind;
         rsp.value_reg_out = w.store_value_reg;
         rsp.value_immediate = w.store_from_imm ? w.store_imm_word : 32'd0;
      end
   end

endmodule

// ----- tb/x86_copy_fill_loop_recognizer_tb.sv -----
// ----------------------------------------------------------------------------
// x86_copy_fill_loop_recognizer_tb
// streams candidate loop bodies into the recognizer, byte by byte, and checks
// each verdict against a cycle-free model of the decoder kept in the bench.
// a few hand-written windows come first, then random loops (mostly well formed
// with random registers, widths and advance forms, some corrupted) and noise,
// with random gaps on both channels and long-mode switches between windows.
// ----------------------------------------------------------------------------
module x86_copy_fill_loop_recognizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xcfl_pkg::*;

   // opcodes and prefixes
   localparam logic [7:0] OP_ESC      = 8'h0f;
   localparam logic [7:0] OP_MOV_LD   = 8'h8b;
   localparam logic [7:0] OP_MOV_LD8  = 8'h8a;
   localparam logic [7:0] OP_MOV_ST   = 8'h89;
   localparam logic [7:0] OP_MOV_ST8  = 8'h88;
   localparam logic [7:0] OP_MOV_IMM  = 8'hc7;
   localparam logic [7:0] OP_GRP1     = 8'h81;
   localparam logic [7:0] OP_GRP1_I8  = 8'h83;
   localparam logic [7:0] OP_LEA      = 8'h8d;
   localparam logic [7:0] OP_GRP5     = 8'hff;
   localparam logic [7:0] OP_LOOP     = 8'he2;
   localparam logic [7:0] OP_JNZ      = 8'h75;
   localparam logic [7:0] OP_INC_R32  = 8'h40;
   localparam logic [7:0] OP_DEC_R32  = 8'h48;
   localparam logic [7:0] OP_NOP      = 8'h90;
   localparam logic [7:0] OP_ADD_RM8  = 8'h00;
   localparam logic [7:0] REX_W       = 8'h48;
   localparam logic [7:0] PFX_OPSZ    = 8'h66;
   localparam logic [7:0] PFX_REPNE   = 8'hf2;
   localparam logic [7:0] PFX_REP     = 8'hf3;
   localparam logic [7:0] OP2_MOVQ_LD = 8'h6f;
   localparam logic [7:0] OP2_MOVQ_ST = 8'h7f;
   localparam logic [7:0] OP2_MOVU_LD = 8'h10;
   localparam logic [7:0] OP2_MOVU_ST = 8'h11;
   localparam logic [7:0] OP2_MOVA_LD = 8'h28;
   localparam logic [7:0] OP2_MOVA_ST = 8'h29;
   localparam int         RANDOM_BYTES = 1200;
   localparam int         STALL_LIMIT  = 3000;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   xcfl_stream_if #(.payload_type(req_type)) req_ch ();
   xcfl_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   x86_copy_fill_loop_recognizer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   bit          lm_mode;
   logic [7:0]  w_pos, w_prefix, w_rex, w_op, w_op2, w_modrm, w_insns;
   phase_type   w_phase;
   logic [31:0] w_imm, w_imm_word;
   logic [2:0]  w_imm_left, w_imm_size;
   bit          w_fail, w_tail, w_load, w_store, w_from_imm;
   logic [2:0]  w_ctr, ld_reg, ld_kind, ld_ptr, st_reg, st_kind, st_ptr;
   logic [4:0]  ld_w, st_w;
   logic [31:0] w_adv [8];

   function automatic void clear_window();
      w_pos = '0; w_phase = PH_START; w_prefix = '0; w_rex = '0;
      w_op = '0; w_op2 = '0; w_modrm = '0; w_imm = '0; w_imm_left = '0;
      w_imm_size = '0; w_fail = 0; w_tail = 0; w_load = 0; w_store = 0;
      w_from_imm = 0; w_ctr = '0; ld_reg = '0; ld_kind = '0; ld_w = '0;
      ld_ptr = '0; st_reg = '0; st_kind = '0; st_w = '0; st_ptr = '0;
      w_imm_word = '0; w_insns = '0;
      foreach (w_adv[i]) w_adv[i] = '0;
   endfunction

   function automatic void bump_insns(int n);
      w_insns = (int'(w_insns) + n > 255) ? 8'd255 : 8'(int'(w_insns) + n);
   endfunction

   function automatic void close_insn();
      bump_insns(1);
      w_phase = PH_START;
      w_prefix = '0;
      w_rex = '0;
   endfunction

   function automatic bit plain_mem(logic [7:0] m);
      return m[7:6] == 2'b00 && m[2:0] != 3'd4 && m[2:0] != 3'd5;
   endfunction

   function automatic void open_imm(logic [2:0] n);
      w_imm = '0;
      w_imm_size = n;
      w_imm_left = n;
      w_phase = PH_IMM;
   endfunction

   function automatic void on_opcode(logic [7:0] b);
      bit pre;
      pre = w_prefix != 0;
      w_op = b;
      if (!lm_mode && b[7:4] == 4'h4) begin
         if (pre) begin
            w_fail = 1;
            return;
         end
         w_adv[b[2:0]] += b[3] ? 32'hffffffff : 32'd1;
         close_insn();
         return;
      end
      case (b)
         OP_ESC: w_phase = PH_OP2;
         OP_MOV_LD, OP_MOV_LD8: begin
            if (pre || w_load || w_store) w_fail = 1;
            else w_phase = PH_MODRM;
         end
         OP_MOV_ST, OP_MOV_ST8: begin
            if (pre || w_store) w_fail = 1;
            else w_phase = PH_MODRM;
         end
         OP_MOV_IMM: begin
            if (pre || w_rex != 0 || w_store) w_fail = 1;
            else w_phase = PH_MODRM;
         end
         OP_GRP1, OP_GRP1_I8, OP_LEA, OP_GRP5: begin
            if (pre) w_fail = 1;
            else w_phase = PH_MODRM;
         end
         OP_LOOP: begin
            if (pre || w_rex != 0) w_fail = 1;
            else begin
               w_ctr = 3'd1;
               bump_insns(1);
               w_phase = PH_REL;
            end
         end
         default: w_fail = 1;
      endcase
   endfunction

   function automatic void on_modrm(logic [7:0] m);
      logic [2:0] rm, rg, kind;
      logic [4:0] size;
      bit st;
      rm = m[2:0];
      rg = m[5:3];
      w_modrm = m;
      if (w_op == OP_ESC) begin
         kind = VK_XMM;
         size = 5'd16;
         if (w_op2 == OP2_MOVQ_LD || w_op2 == OP2_MOVQ_ST) begin
            if (w_prefix == 0) begin
               kind = VK_MMX;
               size = 5'd8;
            end
            st = w_op2 == OP2_MOVQ_ST;
         end else begin
            if (w_prefix == PFX_REPNE) size = 5'd8;
            else if (w_prefix == PFX_REP) size = 5'd4;
            st = w_op2[0];
         end
         if (!plain_mem(m) || w_store || (!st && w_load)) begin
            w_fail = 1;
            return;
         end
         if (st) begin
            w_store = 1; w_from_imm = 0; st_ptr = rm; st_reg = rg;
            st_kind = kind; st_w = size;
         end else begin
            w_load = 1; ld_ptr = rm; ld_reg = rg; ld_kind = kind; ld_w = size;
         end
         close_insn();
      end else if (w_op inside {OP_MOV_LD, OP_MOV_LD8, OP_MOV_ST, OP_MOV_ST8}) begin
         size = w_op[0] ? (w_rex[3] ? 5'd8 : 5'd4) : 5'd1;
         if (!plain_mem(m)) begin
            w_fail = 1;
            return;
         end
         if (w_op == OP_MOV_LD || w_op == OP_MOV_LD8) begin
            w_load = 1; ld_ptr = rm; ld_reg = rg; ld_kind = VK_GPR; ld_w = size;
         end else begin
            w_store = 1; w_from_imm = 0; st_ptr = rm; st_reg = rg;
            st_kind = VK_GPR; st_w = size;
         end
         close_insn();
      end else if (w_op == OP_MOV_IMM) begin
         if (!plain_mem(m) || rg != 0) begin
            w_fail = 1;
            return;
         end
         w_store = 1; w_from_imm = 1; st_ptr = rm; st_reg = '0;
         st_kind = VK_IMM; st_w = 5'd4;
         open_imm(3'd4);
      end else if (w_op == OP_GRP1 || w_op == OP_GRP1_I8) begin
         if (m[7:6] != 2'b11 || (rg != 0 && rg != 3'd5)) w_fail = 1;
         else open_imm(w_op == OP_GRP1_I8 ? 3'd1 : 3'd4);
      end else if (w_op == OP_LEA) begin
         if ((m[7:6] != 2'b01 && m[7:6] != 2'b10) || rm == 3'd4 || rg != rm) w_fail = 1;
         else open_imm(m[7:6] == 2'b01 ? 3'd1 : 3'd4);
      end else begin
         if (m[7:6] != 2'b11 || rg > 3'd1) w_fail = 1;
         else if (rg == 0) begin
            w_adv[rm] += 32'd1;
            close_insn();
         end else begin
            w_ctr = rm;
            bump_insns(2);
            w_phase = PH_JNZ;
         end
      end
   endfunction

   function automatic void on_imm(logic [7:0] b);
      logic [31:0] v;
      logic [2:0]  rm;
      rm = w_modrm[2:0];
      w_imm = {b, w_imm[31:8]};
      if (w_imm_left > 0) w_imm_left--;
      if (w_imm_left != 0) return;
      v = (w_imm_size == 3'd1) ? {{24{w_imm[31]}}, w_imm[31:24]} : w_imm;
      if (w_op == OP_MOV_IMM) begin
         w_imm_word = v;
         close_insn();
      end else if (w_op == OP_LEA || w_modrm[5:3] == 0) begin
         w_adv[rm] += v;
         close_insn();
      end else if (v == 32'd1) begin
         w_ctr = rm;
         bump_insns(2);
         w_phase = PH_JNZ;
      end else w_fail = 1;
   endfunction

   function automatic void on_byte(logic [7:0] b, logic [7:0] at);
      case (w_phase)
         PH_START: begin
            if (b == PFX_OPSZ || b == PFX_REPNE || b == PFX_REP) begin
               if (w_prefix != 0 && w_prefix != b) w_fail = 1;
               else w_prefix = b;
            end else if (lm_mode && b[7:4] == 4'h4) begin
               w_rex = b;
               if (b[2:0] != 0) w_fail = 1;
               else w_phase = PH_OPCODE;
            end else on_opcode(b);
         end
         PH_OPCODE: on_opcode(b);
         PH_OP2: begin
            if (b inside {OP2_MOVQ_LD, OP2_MOVQ_ST, OP2_MOVU_LD, OP2_MOVU_ST,
                          OP2_MOVA_LD, OP2_MOVA_ST}) begin
               w_op2 = b;
               w_phase = PH_MODRM;
            end else w_fail = 1;
         end
         PH_MODRM: on_modrm(b);
         PH_IMM: on_imm(b);
         PH_JNZ: begin
            if (b == OP_JNZ) w_phase = PH_REL;
            else w_fail = 1;
         end
         PH_REL: begin
            if (int'($signed(b)) != -(int'(at) + 1)) w_fail = 1;
            else w_tail = 1;
         end
         default: w_fail = 1;
      endcase
   endfunction

   function automatic rsp_type judge();
      rsp_type r;
      bit ok, ptr;
      logic [2:0] src;
      logic [4:0] elem;
      r = '0;
      ok = !w_fail && w_tail && w_store;
      src = st_ptr;
      elem = st_w;
      if (ok && w_load) begin
         if (ld_reg != st_reg || ld_kind != st_kind || ld_w != st_w) ok = 0;
         if (ld_kind == VK_GPR && (ld_reg == ld_ptr || ld_reg == st_ptr)) ok = 0;
         src = ld_ptr;
      end
      if (!(elem inside {5'd1, 5'd4, 5'd8, 5'd16})) ok = 0;
      for (int i = 0; i < 8; i++) begin
         ptr = i == st_ptr || (w_load && i == src);
         if (w_adv[i] != (ptr ? 32'(elem) : 32'd0)) ok = 0;
      end
      if (w_ctr == st_ptr || (w_load && w_ctr == src) || w_adv[w_ctr] != 0) ok = 0;
      if (!w_load && st_kind == VK_GPR && (st_reg == st_ptr || st_reg == w_ctr)) ok = 0;
      if (ok) begin
         r.accepted = 1'b1;
         r.pattern_length = w_pos;
         r.insn_total = w_insns;
         r.element_size = elem;
         r.loop_kind = !w_load;
         r.source_reg = src;
         r.dest_reg = st_ptr;
         r.counter_reg = w_ctr;
         r.value_class = w_load ? VK_NONE : st_kind;
         r.value_reg_out = st_reg;
         r.value_immediate = w_from_imm ? w_imm_word : 32'd0;
      end
      return r;
   endfunction

   // advances the window by one byte; returns 1 with the verdict on a last byte
   function automatic bit absorb(logic [7:0] b, bit last, output rsp_type verdict);
      logic [7:0] at;
      verdict = '0;
      if (!w_tail) begin
         at = w_pos;
         if (w_pos != 8'd255) w_pos++;
         if (!w_fail) begin
            if (int'(at) >= MaxLoopBytes) w_fail = 1;
            else on_byte(b, at);
         end
      end
      if (!last) return 0;
      verdict = judge();
      clear_window();
      return 1;
   endfunction

   // ------------------------------------------------------ checking side
   rsp_type verdict_q[$];
   bit      req_typed;
   bit      quiet;
   int      errors, shown, idle_cycles, bytes_in, windows_out, loops_taken;

   always @(posedge clock) begin
      rsp_type v;
      rsp_type want;
      bit moved;
      if (reset) begin
         lm_mode = 0;
         clear_window();
      end else begin
         moved = 0;
         if (csr_we) lm_mode = csr_wdata;
         if (req_ch.valid && req_ch.ready) begin
            moved = 1;
            bytes_in++;
            if (absorb(req_ch.payload.code_byte, req_ch.payload.last_byte, v)) begin
               if (req_typed) v = '0;
               verdict_q.push_back(v);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1;
            windows_out++;
            if (rsp_ch.payload.accepted) loops_taken++;
            if (verdict_q.size() == 0) begin
               errors++;
               if (shown++ < 10) $display("unexpected verdict %p", rsp_ch.payload);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_ch.payload !== want) begin
                  errors++;
                  if (shown++ < 10)
                     $display("verdict mismatch\n  expected %p\n  actual   %p",
                              want, rsp_ch.payload);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // random gap lengths, for stalls of the verdict consumer and gaps between request bytes
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   int rsp_hold;
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 0;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold <= pick_gap();
      end
   end

   // ------------------------------------------------------- stimulus side
   logic [7:0] win[$];

   task automatic put(logic [7:0] b);
      win.push_back(b);
   endtask

   task automatic send_window(bit typed);
      int g;
      foreach (win[i]) begin
         req_ch.valid <= 1'b1;
         req_ch.payload <= '{code_byte: win[i], last_byte: i == win.size() - 1};
         req_typed <= typed;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         g = pick_gap();
         if (g > 0 && i != win.size() - 1) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_mode(bit m);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic emit_move(int style, logic [7:0] pfx, bit wide, bit st,
                            logic [2:0] v, logic [2:0] ptr);
      case (style)
         0: begin
            if (wide) put(REX_W);
            put(st ? OP_MOV_ST : OP_MOV_LD);
         end
         1: put(st ? OP_MOV_ST8 : OP_MOV_LD8);
         2, 3: begin
            if (style == 3) put(pfx);
            put(OP_ESC);
            put(st ? OP2_MOVQ_ST : OP2_MOVQ_LD);
         end
         4: begin
            if (pfx != 0) put(pfx);
            put(OP_ESC);
            put(st ? OP2_MOVU_ST : OP2_MOVU_LD);
         end
         default: begin
            put(OP_ESC);
            put(st ? OP2_MOVA_ST : OP2_MOVA_LD);
         end
      endcase
      put({2'b00, v, ptr});
   endtask

   task automatic emit_advance(logic [2:0] p, logic [4:0] elem, bit lm);
      int how;
      how = $urandom_range(0, 4);
      if (how == 4 && elem > 4) how = 0;
      // overshoot then step back, so the sum must wrap to come out right
      if ($urandom_range(0, 5) == 0) begin
         put(OP_GRP1_I8); put({2'b11, 3'd0, p}); put(8'(elem + 3));
         put(OP_GRP1_I8); put({2'b11, 3'd0, p}); put(8'hfd);
         return;
      end
      case (how)
         0: begin put(OP_GRP1_I8); put({2'b11, 3'd0, p}); put(8'(elem)); end
         1: begin
            put(OP_GRP1); put({2'b11, 3'd0, p}); put(8'(elem));
            put(8'h00); put(8'h00); put(8'h00);
         end
         2: begin put(OP_LEA); put({2'b01, p, p}); put(8'(elem)); end
         3: begin
            put(OP_LEA); put({2'b10, p, p}); put(8'(elem));
            put(8'h00); put(8'h00); put(8'h00);
         end
         default: begin
            repeat (elem) begin
               if (!lm && $urandom_range(0, 1)) put(OP_INC_R32 | 8'(p));
               else begin put(OP_GRP5); put({2'b11, 3'd0, p}); end
            end
         end
      endcase
   endtask

   // a plausible copy or fill loop, sometimes corrupted afterwards
   task automatic make_loop(bit lm);
      logic [2:0] pool [6];
      logic [2:0] src, dst, cnt, v;
      logic [7:0] pfx;
      logic [4:0] elem;
      int style, n;
      bit fill, imm_fill, wide;
      pool = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7};
      win.delete();
      src = pool[$urandom_range(0, 5)];
      do dst = pool[$urandom_range(0, 5)]; while (dst == src);
      do cnt = 3'($urandom_range(0, 7)); while (cnt == src || cnt == dst);
      do v = 3'($urandom_range(0, 7)); while (v == src || v == dst || v == cnt);
      fill = $urandom_range(0, 2) == 0;
      imm_fill = fill && $urandom_range(0, 1);
      style = $urandom_range(0, 5);
      wide = lm && $urandom_range(0, 1);
      pfx = 8'h00;
      case (style)
         0: elem = wide ? 5'd8 : 5'd4;
         1: elem = 5'd1;
         2: elem = 5'd8;
         3: begin pfx = PFX_OPSZ; elem = 5'd16; end
         4: begin
            n = $urandom_range(0, 2);
            elem = n == 0 ? 5'd16 : (n == 1 ? 5'd8 : 5'd4);
            pfx = n == 0 ? 8'h00 : (n == 1 ? PFX_REPNE : PFX_REP);
         end
         default: elem = 5'd16;
      endcase
      if (!fill) emit_move(style, pfx, wide, 1'b0, v, src);
      if (imm_fill) begin
         elem = 5'd4;
         put(OP_MOV_IMM); put({2'b00, 3'd0, dst});
         repeat (4) put(8'($urandom_range(0, 255)));
      end else emit_move(style, pfx, wide, 1'b1, v, dst);
      // inc/dec pairs that cancel, pushing the tail toward the size limit
      if (!lm && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 30)) begin
            put(OP_INC_R32 | 8'(v));
            put(OP_DEC_R32 | 8'(v));
         end
      emit_advance(dst, elem, lm);
      if (!fill) emit_advance(src, elem, lm);
      case ($urandom_range(0, 3))
         0: put(OP_LOOP);
         1: begin put(OP_GRP5); put({2'b11, 3'd1, cnt}); put(OP_JNZ); end
         2: begin put(OP_GRP1_I8); put({2'b11, 3'd5, cnt}); put(8'h01); put(OP_JNZ); end
         default: begin
            put(OP_GRP1); put({2'b11, 3'd5, cnt});
            put(8'h01); put(8'h00); put(8'h00); put(8'h00); put(OP_JNZ);
         end
      endcase
      put(8'(-(int'(win.size()) + 1)));
      if ($urandom_range(0, 4) == 0) win[$urandom_range(0, win.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, win.size() - 1);
         while (win.size() > n) void'(win.pop_back());
      end
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) put(8'($urandom));
   endtask

   task automatic make_noise(int len);
      win.delete();
      repeat (len) put(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int nwin, lm_windows;
      bit lm;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      req_typed = 1'b0;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_mode(1'b0);

      // directed windows, 32-bit code
      win = '{OP_NOP};
      send_window(1'b1);
      // dword copy closed by dec/jnz
      win = '{OP_MOV_LD, 8'h06, OP_MOV_ST, 8'h07, OP_GRP1_I8, 8'hc6, 8'h04,
              OP_GRP1_I8, 8'hc7, 8'h04, OP_GRP5, 8'hc9, OP_JNZ, 8'hf2};
      send_window(1'b0);
      // immediate fill of all ones closed by loop
      win = '{OP_MOV_IMM, 8'h07, 8'hff, 8'hff, 8'hff, 8'hff,
              OP_GRP1_I8, 8'hc7, 8'h04, OP_LOOP, 8'hf5};
      send_window(1'b0);
      // window ends inside an instruction
      win = '{OP_GRP5};
      send_window(1'b1);
      win = '{OP_ADD_RM8};
      send_window(1'b1);

      // random part
      nwin = 0;
      lm = 1'b1;
      lm_windows = 0;
      set_mode(lm);
      while (bytes_in < RANDOM_BYTES + 28) begin
         if (nwin > 0 && $urandom_range(0, 5) == 0) begin
            lm = $urandom_range(0, 1);
            if (lm != lm_mode) set_mode(lm);
         end
         if (nwin == 12) drain();
         quiet = $urandom_range(0, 4) == 0;
         if (nwin == 20) make_noise(300);
         else if ($urandom_range(0, 4) == 0) make_noise($urandom_range(1, 80));
         else make_loop(lm);
         if (lm) lm_windows++;
         send_window(1'b0);
         nwin++;
      end
      quiet = 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      $display("%0d bytes in %0d windows (%0d in long mode), %0d loops recognized",
               bytes_in, windows_out, lm_windows, loops_taken);
      $display("%0d verdict mismatches", errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- x86_copy_fill_loop_recognizer.f -----
+incdir+hdl
hdl/xcfl_pkg.sv
hdl/xcfl_stream_if.sv
hdl/xcfl_decoder.sv
hdl/xcfl_verdict.sv
hdl/x86_copy_fill_loop_recognizer.sv
tb/x86_copy_fill_loop_recognizer_tb.sv
